// ===== rtl/accelerating_cursor_motion_defines.svh =====
// assertion macros for the cursor motion checker
`ifndef ACCELERATING_CURSOR_MOTION_DEFINES_SVH
`define ACCELERATING_CURSOR_MOTION_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ACM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define ACM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/acm_pkg.sv =====
// shared types and constants for the cursor motion integrator
`default_nettype none

package acm_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_START_X   = 3'd1,
    CMD_START_Y   = 3'd2,
    CMD_STOP_X    = 3'd3,
    CMD_STOP_Y    = 3'd4,
    CMD_SET_POINT = 3'd5
  } cmd_t;

  // register index is paddr[2]
  localparam logic REG_ACCEL_MAG = 1'b0;
  localparam logic REG_VEL_LIMIT = 1'b1;

  localparam int MAG_W = 15;
  localparam int FRAC_BITS = 12;
  localparam int TICK_DIV = 20;

  localparam logic [MAG_W-1:0] ACCEL_RESET = 15'd204;
  localparam logic [MAG_W-1:0] VLIM_RESET  = 15'd20480;
  localparam logic [31:0] POS_X_RESET = 32'h000A_0000;
  localparam logic [31:0] POS_Y_RESET = 32'h0006_4000;

  // elapsed magnitudes at or above 2^21 saturate the velocity unless the acceleration is zero
  localparam int ELAPSED_BITS = 21;
  localparam int PROD_W = MAG_W + ELAPSED_BITS;

  // quotient magnitude cap: anything this large saturates any velocity
  localparam int Q_W = 17;
  localparam logic [Q_W-1:0] Q_CAP = 17'h1_0000;
  localparam logic [PROD_W-1:0] PROD_CAP = PROD_W'(TICK_DIV * 65536);

  // x / 20 == (x * RECIP) >> RECIP_SHIFT for every x below PROD_CAP
  localparam int RECIP_W = 20;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP = 20'd838861;
  localparam int SCALED_W = ELAPSED_BITS + RECIP_W;

  typedef struct packed {
    logic [PROD_W-1:0] prod;  // |acc| * |elapsed| low part
    logic              big;   // |elapsed| beyond ELAPSED_BITS, acc nonzero
    logic              neg;   // sign of acc * elapsed
  } axis_prod_t;

  typedef struct packed {
    cmd_t       cmd;
    logic       ax;
    logic       ay;
    axis_prod_t px;
    axis_prod_t py;
    logic [15:0] point_x;
    logic [15:0] point_y;
  } acm_item_t;

endpackage

`default_nettype wire

// ===== rtl/accelerating_cursor_motion.sv =====
// top level of the two-axis accelerating cursor motion integrator
`default_nettype none

// Two-axis cursor integrator in 20.12 fixed point. Each command transfer
// yields exactly one result transfer carrying the screen position (integer
// part of the 20.12 position, low 16 bits) and a moved flag that is set
// only for ticks that would post a position message. The block takes one
// command per cycle while cmd_stall is low; each command is first held in
// the input register and then passes into the result register. The front
// stage runs the axis start/stop/tick bookkeeping and the acceleration
// times elapsed-time multiply; the back stage divides by 20 with a
// reciprocal multiply, clamps the velocity to +-velocity_limit and
// advances the position. A command can still be taken while a finished
// result waits; cmd_stall rises only when both the result register and the
// input register are full. Configuration sits behind an apb port:
// accel_magnitude at 0x0, velocity_limit at 0x4; writes are meant for
// idle periods only.

module accelerating_cursor_motion import acm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // command channel
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire logic [2:0]         command,
  input  wire logic               direction_positive,
  input  wire logic [31:0]        now_ms,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  // result channel
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic                    moved,
  output logic signed [15:0]      screen_x,
  output logic signed [15:0]      screen_y,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  logic             s1_valid;
  logic             s1_move;
  logic             accept;
  acm_item_t        s1_item;
  logic [MAG_W-1:0] accel_mag;
  logic [MAG_W-1:0] vel_limit;

  // input register drains whenever the result register is empty or taken
  assign s1_move   = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = s1_valid && !s1_move;
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;

      if (s1_move) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
    end
  end

  // register index comes from the word address bit
  acm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .sel       (paddr[2]),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .accel_mag (accel_mag),
    .vel_limit (vel_limit)
  );

  // start/stop/tick bookkeeping plus acceleration product
  acm_front u_front (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .command            (command),
    .direction_positive (direction_positive),
    .now_ms             (now_ms),
    .point_x            (point_x),
    .point_y            (point_y),
    .accel_mag          (accel_mag),
    .item               (s1_item)
  );

  // velocity and position update, holds the result
  acm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (s1_move),
    .item      (s1_item),
    .vel_limit (vel_limit),
    .moved     (moved),
    .screen_x  (screen_x),
    .screen_y  (screen_y)
  );

endmodule

`default_nettype wire

// ===== rtl/acm_regs.sv =====
// configuration registers behind the apb port
`default_nettype none

module acm_regs import acm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic             sel,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [MAG_W-1:0] accel_mag,
  output logic      [MAG_W-1:0] vel_limit
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_mag <= ACCEL_RESET;
      vel_limit <= VLIM_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_ACCEL_MAG: accel_mag <= pwdata[MAG_W-1:0];
        REG_VEL_LIMIT: vel_limit <= pwdata[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_ACCEL_MAG: prdata = {(32 - MAG_W)'(0), accel_mag};
      REG_VEL_LIMIT: prdata = {(32 - MAG_W)'(0), vel_limit};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/acm_front.sv =====
// axis control state and acceleration product, input register
`default_nettype none

module acm_front import acm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [2:0]        command,
  input  wire logic              direction_positive,
  input  wire logic [31:0]       now_ms,
  input  wire logic [15:0]       point_x,
  input  wire logic [15:0]       point_y,
  input  wire logic [MAG_W-1:0]  accel_mag,
  output acm_item_t              item
);

  logic             active_x, active_y;
  logic             acc_neg_x, acc_neg_y;
  logic [MAG_W-1:0] acc_mag_x, acc_mag_y;
  logic [31:0]      last_x, last_y;
  cmd_t             cmd;
  acm_item_t        item_next;

  // sign and magnitude of acc * (now - last), elapsed read as signed
  function automatic axis_prod_t elapsed_prod(logic [31:0] now, logic [31:0] last,
                                              logic a_neg, logic [MAG_W-1:0] a_mag);
    logic [31:0] e;
    logic [31:0] e_mag;
    axis_prod_t  r;
    e = now - last;
    e_mag = e[31] ? (~e + 32'd1) : e;
    // a zero acceleration gives a zero product however long the gap
    r.big = (|e_mag[31:ELAPSED_BITS]) && (|a_mag);
    r.prod = a_mag * e_mag[ELAPSED_BITS-1:0];
    r.neg = a_neg ^ e[31];
    return r;
  endfunction

  assign cmd = cmd_t'(command);

  always_comb begin
    item_next.cmd     = cmd;
    item_next.ax      = active_x;
    item_next.ay      = active_y;
    item_next.px      = elapsed_prod(now_ms, last_x, acc_neg_x, acc_mag_x);
    item_next.py      = elapsed_prod(now_ms, last_y, acc_neg_y, acc_mag_y);
    item_next.point_x = point_x;
    item_next.point_y = point_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_x  <= 1'b0;
      active_y  <= 1'b0;
      acc_neg_x <= 1'b0;
      acc_neg_y <= 1'b0;
      acc_mag_x <= '0;
      acc_mag_y <= '0;
      last_x    <= '0;
      last_y    <= '0;
    end else if (accept) begin
      unique case (cmd)
        CMD_TICK: begin
          if (active_x) last_x <= now_ms;
          if (active_y) last_y <= now_ms;
        end
        CMD_START_X: begin
          if (!active_x) begin
            active_x  <= 1'b1;
            acc_neg_x <= !direction_positive;
            acc_mag_x <= accel_mag;
            last_x    <= now_ms;
          end
        end
        CMD_START_Y: begin
          if (!active_y) begin
            active_y  <= 1'b1;
            acc_neg_y <= !direction_positive;
            acc_mag_y <= accel_mag;
            last_y    <= now_ms;
          end
        end
        CMD_STOP_X: begin
          active_x  <= 1'b0;
          acc_neg_x <= 1'b0;
          acc_mag_x <= '0;
        end
        CMD_STOP_Y: begin
          active_y  <= 1'b0;
          acc_neg_y <= 1'b0;
          acc_mag_y <= '0;
        end
        CMD_SET_POINT: begin
          active_x <= 1'b0;
          active_y <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= item_next;
  end

endmodule

`default_nettype wire

// ===== rtl/acm_back.sv =====
// divide by 20, velocity saturation and position update
`default_nettype none

module acm_back import acm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire acm_item_t          item,
  input  wire logic [MAG_W-1:0]   vel_limit,
  output logic                    moved,
  output logic signed [15:0]      screen_x,
  output logic signed [15:0]      screen_y
);

  logic [31:0]        pos_x, pos_y;
  logic signed [15:0] vel_x, vel_y;
  logic signed [15:0] vel_x_tick, vel_y_tick;
  logic signed [15:0] vel_x_new, vel_y_new;
  logic               pos_dirty;
  logic               any_active;

  // vel + trunc(acc * elapsed / 20), clamped to +-lim
  function automatic logic signed [15:0] vel_step(logic signed [15:0] vel,
                                                  axis_prod_t ap,
                                                  logic [MAG_W-1:0] lim);
    logic [SCALED_W-1:0] scaled;
    logic [Q_W-1:0]      q_mag;
    logic signed [17:0]  q;
    logic signed [17:0]  sum;
    logic signed [17:0]  lim_s;
    scaled = ap.prod[ELAPSED_BITS-1:0] * RECIP;
    if (ap.big || (ap.prod >= PROD_CAP)) q_mag = Q_CAP;
    else q_mag = scaled[SCALED_W-1:RECIP_SHIFT];
    q = ap.neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    sum = 18'(vel) + q;
    lim_s = $signed({(18 - MAG_W)'(0), lim});
    priority if (sum > lim_s) vel_step = lim_s[15:0];
    else if (sum < -lim_s) vel_step = 16'(-lim_s);
    else vel_step = sum[15:0];
  endfunction

  assign vel_x_tick = vel_step(vel_x, item.px, vel_limit);
  assign vel_y_tick = vel_step(vel_y, item.py, vel_limit);
  assign vel_x_new  = item.ax ? vel_x_tick : vel_x;
  assign vel_y_new  = item.ay ? vel_y_tick : vel_y;
  assign any_active = item.ax || item.ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= POS_X_RESET;
      pos_y     <= POS_Y_RESET;
      vel_x     <= '0;
      vel_y     <= '0;
      pos_dirty <= 1'b0;
      moved     <= 1'b0;
    end else if (adv) begin
      moved <= 1'b0;
      unique case (item.cmd)
        CMD_TICK: begin
          vel_x <= vel_x_new;
          vel_y <= vel_y_new;
          if (any_active) begin
            pos_x <= pos_x + 32'(vel_x_new);
            pos_y <= pos_y + 32'(vel_y_new);
          end
          if (any_active || pos_dirty) begin
            moved     <= 1'b1;
            pos_dirty <= 1'b0;
          end
        end
        CMD_STOP_X: vel_x <= '0;
        CMD_STOP_Y: vel_y <= '0;
        CMD_SET_POINT: begin
          pos_dirty <= 1'b1;
          pos_x <= {{(32 - 16 - FRAC_BITS){item.point_x[15]}}, item.point_x,
                    FRAC_BITS'(0)};
          pos_y <= {{(32 - 16 - FRAC_BITS){item.point_y[15]}}, item.point_y,
                    FRAC_BITS'(0)};
        end
        default: ;
      endcase
    end
  end

  // integer part, low 16 bits
  assign screen_x = $signed(pos_x[FRAC_BITS+15:FRAC_BITS]);
  assign screen_y = $signed(pos_y[FRAC_BITS+15:FRAC_BITS]);

endmodule

`default_nettype wire

// ===== rtl/acm_checker.sv =====
// port-level checks for the cursor integrator, bound to the top level
`default_nettype none

`include "accelerating_cursor_motion_defines.svh"

module acm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cmd_valid,
  input wire logic               cmd_stall,
  input wire logic               res_valid,
  input wire logic               res_stall,
  input wire logic               moved,
  input wire logic signed [15:0] screen_x,
  input wire logic signed [15:0] screen_y
);

  // leaving reset, nothing pending and commands are taken
  `ACM_ASSERT_NOW(a_reset_empty, $fell(rst), !res_valid && !cmd_stall, "pipeline not empty after reset")

  // commands only back up when a result is waiting on a stalled consumer
  `ACM_ASSERT_NOW(a_stall_cause, cmd_stall, res_valid && res_stall, "command stalled with result side free")

  // a fresh result follows a command transfer through the input register
  `ACM_ASSERT_NOW(a_result_source, $rose(res_valid), $past(cmd_valid && !cmd_stall, 2), "result without a command transfer")

  // a stalled result holds its payload
  `ACM_ASSERT_NEXT(a_result_hold, res_valid && res_stall, res_valid && $stable(moved) && $stable(screen_x) && $stable(screen_y), "stalled result changed")

endmodule

bind accelerating_cursor_motion acm_checker u_acm_checker (.*);

`default_nettype wire
